// File: hw/rtl/sgr_pkg.sv
// Shared constants and types for the stable Givens rotation block.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package sgr_pkg;

	// Operand width and output format.
	localparam int OPW = 32;
	localparam int OUTW = 32;
	localparam int FRAC = 30;

	// Ratio divider: one integer bit and FRAC + 1 fraction bits.
	localparam int DIV_STEPS = FRAC + 2;
	// Tau magnitude, Q1.30 (at most one).
	localparam int TW = FRAC + 1;
	// 1 + tau^2 in Q2.60.
	localparam int QW = 2 * TW;
	// Square root working width and step count.
	localparam int SQW = QW + 1;
	localparam int SQ_STEPS = FRAC + 2;
	// sqrt(1 + tau^2), Q1.30.
	localparam int MW = FRAC + 1;
	// Reciprocal divider: quotient and remainder widths, step count.
	localparam int GQW = FRAC + 2;
	localparam int GRW = MW + 1;
	localparam int G_STEPS = GQW;
	// Radius product width.
	localparam int RPW = OPW + MW;

	// Item class decided at the front.
	typedef enum logic [1:0] {
		KIND_GEN,
		KIND_BZERO,
		KIND_AZERO
	} sgr_kind_t;

	// Control and magnitude that travel with an item down the pipeline.
	typedef struct packed {
		sgr_kind_t        kind;
		logic             a_neg;
		logic             b_neg;
		logic             a_leads;
		logic [OPW-1:0]   big;
	} sgr_side_t;

	// One classified item as held in the queue.
	typedef struct packed {
		sgr_side_t        side;
		logic [OPW-1:0]   lesser;
	} sgr_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/sgr_front.sv
// Front end: takes an operand pair, forms magnitudes and classifies the item.
// Depends on sgr_pkg.
`default_nettype none
module sgr_front (
	input  wire logic                     start,
	input  wire logic                     full,
	input  wire logic [sgr_pkg::OPW-1:0]  a_value,
	input  wire logic [sgr_pkg::OPW-1:0]  b_value,
	output logic                          push,
	output sgr_pkg::sgr_item_t            item
);
	import sgr_pkg::*;

	logic [OPW-1:0] am;
	logic [OPW-1:0] bm;
	logic           an;
	logic           bn;
	logic           a_leads;

	// Magnitudes; the most negative code maps to 2^(OPW-1) exactly.
	assign an = a_value[OPW-1];
	assign bn = b_value[OPW-1];
	assign am = an ? (~a_value + 1'b1) : a_value;
	assign bm = bn ? (~b_value + 1'b1) : b_value;
	assign a_leads = !(bm > am);

	// A transfer happens whenever start is high and the queue has room.
	assign push = start && !full;

	// Classification and ordering of the operands.
	always_comb begin
		item.side.a_neg   = an;
		item.side.b_neg   = bn;
		item.side.a_leads = a_leads;
		item.side.big     = a_leads ? am : bm;
		item.lesser       = a_leads ? bm : am;
		if (bm == '0) begin
			item.side.kind = KIND_BZERO;
		end else if (am == '0) begin
			item.side.kind = KIND_AZERO;
		end else begin
			item.side.kind = KIND_GEN;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sgr_queue.sv
// Two-entry queue between the front end and the arithmetic pipeline.
// Depends on sgr_pkg.
`default_nettype none
module sgr_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire sgr_pkg::sgr_item_t item_in,
	input  wire logic               pop,
	output logic                    full,
	output logic                    valid,
	output sgr_pkg::sgr_item_t      item_out
);
	import sgr_pkg::*;

	sgr_item_t   mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_pop;

	assign full     = (cnt_q == 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign item_out = mem_q[rd_ptr_q];
	assign do_pop   = pop && valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sgr_back.sv
// Arithmetic pipeline: ratio divider, square root, reciprocal divider,
// products and output encoding, one step per stage. Depends on sgr_pkg.
`default_nettype none
module sgr_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire sgr_pkg::sgr_item_t      in_item,
	output logic                         strobe,
	output logic signed [sgr_pkg::OUTW-1:0] cosine,
	output logic signed [sgr_pkg::OUTW-1:0] sine,
	output logic [sgr_pkg::OUTW-1:0]     radius
);
	import sgr_pkg::*;

	localparam logic [OUTW-1:0] Q_ONE = OUTW'(1) << FRAC;
	localparam logic [QW-1:0]   Q_BASE = QW'(1) << (2 * FRAC);
	localparam logic [GRW-1:0]  G_INIT = GRW'(1) << (2 * FRAC + 1 - GQW);
	localparam logic [RPW-1:0]  R_MAX = RPW'({OUTW{1'b1}});

	function automatic logic [OUTW-1:0] enc_sgn(input logic [OUTW-1:0] mag,
		input logic neg);
		logic [OUTW-1:0] cl;
		cl = (mag > Q_ONE) ? Q_ONE : mag;
		return neg ? (~cl + 1'b1) : cl;
	endfunction

	function automatic logic [OUTW-1:0] sat_rad(input logic [RPW-1:0] r);
		return (r > R_MAX) ? {OUTW{1'b1}} : r[OUTW-1:0];
	endfunction

	// Ratio divider registers.
	logic [OPW-1:0]       d1_rem_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] d1_quo_s  [DIV_STEPS];
	sgr_side_t            d1_side_s [DIV_STEPS];
	logic                 d1_vld_s  [DIV_STEPS];
	// Squaring stage registers.
	logic [QW-1:0]        mu_q_s1;
	logic [TW-1:0]        mu_t_s1;
	sgr_side_t            mu_side_s1;
	logic                 mu_vld_s1;
	// Square root registers.
	logic [SQW-1:0]       sq_x_s    [SQ_STEPS];
	logic [SQW-1:0]       sq_r_s    [SQ_STEPS];
	logic [TW-1:0]        sq_t_s    [SQ_STEPS];
	sgr_side_t            sq_side_s [SQ_STEPS];
	logic                 sq_vld_s  [SQ_STEPS];
	// Root rounding stage.
	logic [MW-1:0]        rd_m_s1;
	logic [TW-1:0]        rd_t_s1;
	sgr_side_t            rd_side_s1;
	logic                 rd_vld_s1;
	// Reciprocal divider registers.
	logic [GRW-1:0]       g_rem_s   [G_STEPS];
	logic [GQW-1:0]       g_quo_s   [G_STEPS];
	logic [MW-1:0]        g_m_s     [G_STEPS];
	logic [TW-1:0]        g_t_s     [G_STEPS];
	sgr_side_t            g_side_s  [G_STEPS];
	logic                 g_vld_s   [G_STEPS];
	// Product stage.
	logic [MW+TW-1:0]     ml_gt_s1;
	logic [RPW-1:0]       ml_rp_s1;
	logic [MW-1:0]        ml_g_s1;
	sgr_side_t            ml_side_s1;
	logic                 ml_vld_s1;
	// Output registers.
	logic                 strobe_q;
	logic [OUTW-1:0]      cosine_q;
	logic [OUTW-1:0]      sine_q;
	logic [OUTW-1:0]      radius_q;

	// Ratio divider: the first stage settles the integer bit, the others
	// produce one fraction bit each.
	logic d1_ge0;
	assign d1_ge0 = in_item.lesser >= in_item.side.big;

	always_ff @(posedge clk) begin
		d1_rem_s[0]  <= d1_ge0 ? (in_item.lesser - in_item.side.big) : in_item.lesser;
		d1_quo_s[0]  <= DIV_STEPS'(d1_ge0);
		d1_side_s[0] <= in_item.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_vld_s[0] <= 1'b0;
		end else begin
			d1_vld_s[0] <= in_valid;
		end
	end

	for (genvar k = 1; k < DIV_STEPS; k++) begin : g_div1
		logic [OPW:0] sh;
		logic [OPW:0] df;
		logic         ge;
		assign sh = {d1_rem_s[k-1], 1'b0};
		assign df = sh - {1'b0, d1_side_s[k-1].big};
		assign ge = sh >= {1'b0, d1_side_s[k-1].big};

		always_ff @(posedge clk) begin
			d1_rem_s[k]  <= ge ? df[OPW-1:0] : sh[OPW-1:0];
			d1_quo_s[k]  <= {d1_quo_s[k-1][DIV_STEPS-2:0], ge};
			d1_side_s[k] <= d1_side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_vld_s[k] <= 1'b0;
			end else begin
				d1_vld_s[k] <= d1_vld_s[k-1];
			end
		end
	end

	// Round tau to 30 fraction bits and form 1 + tau^2.
	logic [DIV_STEPS:0] t_sum;
	logic [TW-1:0]      t_val;
	logic [QW-1:0]      t_sq;
	assign t_sum = {1'b0, d1_quo_s[DIV_STEPS-1]} + 1'b1;
	assign t_val = t_sum[TW:1];
	assign t_sq  = t_val * t_val;

	always_ff @(posedge clk) begin
		mu_q_s1    <= Q_BASE + t_sq;
		mu_t_s1    <= t_val;
		mu_side_s1 <= d1_side_s[DIV_STEPS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_vld_s1 <= 1'b0;
		end else begin
			mu_vld_s1 <= d1_vld_s[DIV_STEPS-1];
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SQW-1:0] SqBit = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQW-1:0] x_in;
		logic [SQW-1:0] r_in;
		logic [TW-1:0]  t_in;
		sgr_side_t      s_in;
		logic           v_in;
		logic [SQW-1:0] trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign x_in = {1'b0, mu_q_s1};
			assign r_in = '0;
			assign t_in = mu_t_s1;
			assign s_in = mu_side_s1;
			assign v_in = mu_vld_s1;
		end else begin : g_next
			assign x_in = sq_x_s[k-1];
			assign r_in = sq_r_s[k-1];
			assign t_in = sq_t_s[k-1];
			assign s_in = sq_side_s[k-1];
			assign v_in = sq_vld_s[k-1];
		end

		assign trial = r_in + SqBit;
		assign ge    = x_in >= trial;

		always_ff @(posedge clk) begin
			sq_x_s[k]    <= ge ? (x_in - trial) : x_in;
			sq_r_s[k]    <= ge ? ((r_in >> 1) + SqBit) : (r_in >> 1);
			sq_t_s[k]    <= t_in;
			sq_side_s[k] <= s_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k] <= 1'b0;
			end else begin
				sq_vld_s[k] <= v_in;
			end
		end
	end

	// Round the root to nearest using the remainder.
	logic [SQW-1:0] m_sum;
	assign m_sum = sq_r_s[SQ_STEPS-1]
		+ SQW'(sq_x_s[SQ_STEPS-1] > sq_r_s[SQ_STEPS-1]);

	always_ff @(posedge clk) begin
		rd_m_s1    <= m_sum[MW-1:0];
		rd_t_s1    <= sq_t_s[SQ_STEPS-1];
		rd_side_s1 <= sq_side_s[SQ_STEPS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= sq_vld_s[SQ_STEPS-1];
		end
	end

	// Reciprocal 2^61 / m, one quotient bit per stage.
	for (genvar k = 0; k < G_STEPS; k++) begin : g_recip
		logic [GRW-1:0] rem_in;
		logic [GQW-1:0] quo_in;
		logic [MW-1:0]  m_in;
		logic [TW-1:0]  t_in;
		sgr_side_t      s_in;
		logic           v_in;
		logic [GRW:0]   sh;
		logic [GRW:0]   df;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in = G_INIT;
			assign quo_in = '0;
			assign m_in   = rd_m_s1;
			assign t_in   = rd_t_s1;
			assign s_in   = rd_side_s1;
			assign v_in   = rd_vld_s1;
		end else begin : g_next
			assign rem_in = g_rem_s[k-1];
			assign quo_in = g_quo_s[k-1];
			assign m_in   = g_m_s[k-1];
			assign t_in   = g_t_s[k-1];
			assign s_in   = g_side_s[k-1];
			assign v_in   = g_vld_s[k-1];
		end

		assign sh = {rem_in, 1'b0};
		assign df = sh - (GRW+1)'(m_in);
		assign ge = sh >= (GRW+1)'(m_in);

		always_ff @(posedge clk) begin
			g_rem_s[k]  <= ge ? df[GRW-1:0] : sh[GRW-1:0];
			g_quo_s[k]  <= {quo_in[GQW-2:0], ge};
			g_m_s[k]    <= m_in;
			g_t_s[k]    <= t_in;
			g_side_s[k] <= s_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				g_vld_s[k] <= 1'b0;
			end else begin
				g_vld_s[k] <= v_in;
			end
		end
	end

	// Leading term, then the other term and radius products.
	logic [GQW:0]  g_sum;
	logic [MW-1:0] g_val;
	assign g_sum = {1'b0, g_quo_s[G_STEPS-1]} + 1'b1;
	assign g_val = g_sum[MW:1];

	always_ff @(posedge clk) begin
		ml_gt_s1   <= g_val * g_t_s[G_STEPS-1];
		ml_rp_s1   <= g_side_s[G_STEPS-1].big * g_m_s[G_STEPS-1];
		ml_g_s1    <= g_val;
		ml_side_s1 <= g_side_s[G_STEPS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_vld_s1 <= 1'b0;
		end else begin
			ml_vld_s1 <= g_vld_s[G_STEPS-1];
		end
	end

	// Rounding, sign encoding and selection of the result.
	logic [MW+TW-1:0] h_sum;
	logic [OUTW-1:0]  h_val;
	logic [OUTW-1:0]  g_out;
	logic [RPW-1:0]   r_sum;
	logic [RPW-1:0]   r_big;
	logic [OUTW-1:0]  cos_d;
	logic [OUTW-1:0]  sin_d;
	logic [OUTW-1:0]  rad_d;

	assign h_sum = (ml_gt_s1 >> (FRAC - 1)) + 1'b1;
	assign h_val = h_sum[OUTW:1];
	assign g_out = OUTW'(ml_g_s1);
	assign r_sum = (ml_rp_s1 >> (FRAC - 1)) + 1'b1;
	assign r_big = RPW'(ml_side_s1.big);

	always_comb begin
		case (ml_side_s1.kind)
			KIND_GEN: begin
				if (ml_side_s1.a_leads) begin
					cos_d = enc_sgn(g_out, ml_side_s1.a_neg);
					sin_d = enc_sgn(h_val, ml_side_s1.b_neg);
				end else begin
					cos_d = enc_sgn(h_val, ml_side_s1.a_neg);
					sin_d = enc_sgn(g_out, ml_side_s1.b_neg);
				end
				rad_d = sat_rad(r_sum >> 1);
			end
			KIND_BZERO: begin
				cos_d = enc_sgn(Q_ONE, ml_side_s1.a_neg);
				sin_d = '0;
				rad_d = sat_rad(r_big);
			end
			KIND_AZERO: begin
				cos_d = '0;
				sin_d = enc_sgn(Q_ONE, ml_side_s1.b_neg);
				rad_d = sat_rad(r_big);
			end
			default: begin
				cos_d = '0;
				sin_d = '0;
				rad_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cosine_q <= cos_d;
		sine_q   <= sin_d;
		radius_q <= rad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ml_vld_s1;
		end
	end

	assign strobe = strobe_q;
	assign cosine = $signed(cosine_q);
	assign sine   = $signed(sine_q);
	assign radius = radius_q;
endmodule
`default_nettype wire

// File: hw/rtl/stable_givens_rotation.sv
// Top level of the stable Givens rotation block.
// Depends on sgr_pkg, sgr_front, sgr_queue and sgr_back.
`default_nettype none

// The block takes one operand pair per clock cycle and returns the rotation
// cosine, sine and radius in the order the pairs arrived. The pipeline holds
// three bit-per-stage units, the 32-stage ratio divider, the 32-stage square
// root and the 32-stage reciprocal divider, plus the squaring, rounding,
// product and output stages. Each result is shown for one cycle with strobe
// high and must be taken then, since the receiver cannot stall the pipeline.
// busy never rises: the pipeline takes an item from the queue in every cycle
// one is waiting, so the queue never holds more than one.
module stable_givens_rotation (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [sgr_pkg::OPW-1:0] a_value,
	input  wire logic signed [sgr_pkg::OPW-1:0] b_value,
	output logic                               strobe,
	output logic signed [sgr_pkg::OUTW-1:0]    cosine,
	output logic signed [sgr_pkg::OUTW-1:0]    sine,
	output logic [sgr_pkg::OUTW-1:0]           radius
);
	import sgr_pkg::*;

	logic      push;
	logic      full;
	logic      q_valid;
	sgr_item_t f_item;
	sgr_item_t q_item;

	assign busy = full;

	// Classification of each incoming pair.
	sgr_front u_front (
		.start   (start),
		.full    (full),
		.a_value (a_value),
		.b_value (b_value),
		.push    (push),
		.item    (f_item)
	);

	// Queue; the pipeline takes an item every cycle one is waiting.
	sgr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (f_item),
		.pop      (q_valid),
		.full     (full),
		.valid    (q_valid),
		.item_out (q_item)
	);

	// Arithmetic pipeline.
	sgr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_item  (q_item),
		.strobe   (strobe),
		.cosine   (cosine),
		.sine     (sine),
		.radius   (radius)
	);
endmodule
`default_nettype wire

// File: hw/rtl/sgr_checker.sv
// Port-level checks for the stable Givens rotation block, and the bind
// that attaches them to the top level. Depends on sgr_pkg.
`default_nettype none
module sgr_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic signed [sgr_pkg::OPW-1:0] a_value,
	input wire logic signed [sgr_pkg::OPW-1:0] b_value,
	input wire logic                           strobe,
	input wire logic signed [sgr_pkg::OUTW-1:0] cosine,
	input wire logic signed [sgr_pkg::OUTW-1:0] sine,
	input wire logic [sgr_pkg::OUTW-1:0]       radius
);
	import sgr_pkg::*;

	localparam logic signed [OUTW-1:0] P_ONE = OUTW'(1) << FRAC;
	localparam logic signed [OUTW-1:0] N_ONE = -(OUTW'(1) << FRAC);

	// The queue never fills because the pipeline drains it every cycle.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised although the pipeline never stalls");

	// Cosine stays within plus or minus one.
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (cosine <= P_ONE && cosine >= N_ONE))
		else $error("cosine outside the unit range");

	// Sine stays within plus or minus one.
	a_sin_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (sine <= P_ONE && sine >= N_ONE))
		else $error("sine outside the unit range");

	// A zero radius only comes from a pair of zeros, which gives the identity.
	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && radius == '0) |-> (cosine == P_ONE && sine == '0))
		else $error("zero radius without identity rotation");

	// No result can appear straight after reset is released.
	a_no_early_result: assert property (@(posedge clk)
		$rose(arst_n) |-> !strobe)
		else $error("result strobe right after reset");
endmodule

bind stable_givens_rotation sgr_checker u_sgr_checker (.*);
`default_nettype wire

// File: bench/stable_givens_rotation_checker.sv
// Result checker for the stable Givens rotation block: predicts each rotation
// from the transferred operand pair and compares it with the strobed result.
// Depends on sgr_pkg for the operand and output widths.
module stable_givens_rotation_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic                                busy,
	input  wire logic signed [sgr_pkg::OPW-1:0]      a_value,
	input  wire logic signed [sgr_pkg::OPW-1:0]      b_value,
	input  wire logic                                strobe,
	input  wire logic signed [sgr_pkg::OUTW-1:0]     cosine,
	input  wire logic signed [sgr_pkg::OUTW-1:0]     sine,
	input  wire logic [sgr_pkg::OUTW-1:0]            radius,
	output int                                       fail_count,
	output int                                       pending_count,
	output int                                       rotations_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import sgr_pkg::*;

	localparam logic [63:0] UNITY = 64'd1 << FRAC;

	typedef struct {
		logic [OUTW-1:0] cos_q;
		logic [OUTW-1:0] sin_q;
		logic [OUTW-1:0] rad;
	} rotation_t;

	rotation_t expected_rotations[$];
	int mismatch_count;

	// Signed Q1.30 from a magnitude and a sign, clamped to one.
	function automatic logic [OUTW-1:0] to_q130(logic [63:0] mag, logic neg);
		logic [63:0] m;
		m = (mag > UNITY) ? UNITY : mag;
		return neg ? OUTW'(64'd0 - m) : OUTW'(m);
	endfunction

	function automatic logic [OUTW-1:0] clamp_radius(logic [63:0] r);
		return (r > 64'hFFFF_FFFF) ? '1 : OUTW'(r);
	endfunction

	// Bitwise integer square root, rounded to nearest afterwards by the caller.
	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] acc, bitv;
		acc = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= acc + bitv) begin
				x = x - (acc + bitv);
				acc = (acc >> 1) + bitv;
			end else begin
				acc = acc >> 1;
			end
			bitv = bitv >> 2;
		end
		return acc;
	endfunction

	// Works out the rotation for one operand pair.
	function automatic rotation_t rotate_pair(logic [OPW-1:0] a_raw, logic [OPW-1:0] b_raw);
		rotation_t r;
		logic [63:0] a_mag, b_mag, big, lesser, quo, tau, q, m, g, h;
		logic [127:0] prod;
		logic a_neg, b_neg, a_big;
		a_neg = a_raw[OPW-1];
		b_neg = b_raw[OPW-1];
		a_mag = a_neg ? 64'(OPW'(-a_raw)) : 64'(a_raw);
		b_mag = b_neg ? 64'(OPW'(-b_raw)) : 64'(b_raw);
		if (b_mag == 0) begin
			r.cos_q = to_q130(UNITY, a_neg && a_mag != 0);
			r.sin_q = 0;
			r.rad = clamp_radius(a_mag);
			return r;
		end
		if (a_mag == 0) begin
			r.cos_q = 0;
			r.sin_q = to_q130(UNITY, b_neg);
			r.rad = clamp_radius(b_mag);
			return r;
		end
		a_big = !(b_mag > a_mag);
		big = a_big ? a_mag : b_mag;
		lesser = a_big ? b_mag : a_mag;
		// Ratio with 31 fraction bits, rounded half up to 30.
		quo = ((lesser << 31) / big);
		tau = (quo + 1) >> 1;
		q = (64'd1 << 60) + tau * tau;
		m = root_floor(q);
		if (q - m * m > m) m = m + 1;
		g = ((64'd1 << 61) / m + 1) >> 1;
		h = (((g * tau) >> 29) + 1) >> 1;
		prod = 128'(big) * 128'(m);
		r.rad = clamp_radius(64'(((prod >> 29) + 1) >> 1));
		r.cos_q = a_big ? to_q130(g, a_neg) : to_q130(h, a_neg);
		r.sin_q = a_big ? to_q130(h, b_neg) : to_q130(g, b_neg);
		return r;
	endfunction

	task automatic report_field(string label, logic [OUTW-1:0] want, logic [OUTW-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
					$realtime, label, want, want, got, got);
		end
	endtask

	// Predict on every transfer and check on every strobe.
	always @(posedge clk or negedge arst_n) begin
		rotation_t want;
		if (!arst_n) begin
			expected_rotations.delete();
			mismatch_count = 0;
			rotations_checked = 0;
			pending_count = 0;
		end else begin
			if (strobe) begin
				if (expected_rotations.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%t: result with no pair waiting", $realtime);
				end else begin
					want = expected_rotations.pop_front();
					report_field("cosine", want.cos_q, cosine);
					report_field("sine", want.sin_q, sine);
					report_field("radius", want.rad, radius);
					rotations_checked++;
				end
			end
			if (start && !busy)
				expected_rotations.push_back(rotate_pair(a_value, b_value));
			pending_count = expected_rotations.size();
		end
	end

	assign fail_count = mismatch_count;
endmodule

// File: bench/stable_givens_rotation_tb.sv
// Top of the stable Givens rotation testbench: clock, reset and operand stimulus.
// Depends on sgr_pkg, the block and stable_givens_rotation_checker.
module stable_givens_rotation_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sgr_pkg::*;

	localparam int LATENCY = 100;
	localparam int RANDOM_PAIRS = 1750;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic signed [OPW-1:0] a_value = '0;
	logic signed [OPW-1:0] b_value = '0;
	wire logic busy, strobe;
	wire logic signed [OUTW-1:0] cosine, sine;
	wire logic [OUTW-1:0] radius;
	int fail_count, pending_count, rotations_checked;

	always #10 clk = ~clk;

	stable_givens_rotation dut (.*);

	stable_givens_rotation_checker checker_i (.*);

	// Hold one pair on the ports until it is transferred.
	task automatic send_pair(logic [OPW-1:0] a, logic [OPW-1:0] b);
		start <= 1'b1;
		a_value <= a;
		b_value <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Operands of assorted magnitude, so that ties, zeros and extremes recur.
	function automatic logic [OPW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {1'b1, {(OPW-1){1'b0}}};
			2: return {1'b0, {(OPW-1){1'b1}}};
			3: return OPW'($urandom_range(0, 7)) - OPW'(3);
			4: return OPW'($signed($urandom_range(0, 2000)) - 1000);
			default: return OPW'($urandom);
		endcase
	endfunction

	localparam logic [OPW-1:0] MOST_NEG = {1'b1, {(OPW-1){1'b0}}};
	localparam logic [OPW-1:0] MOST_POS = {1'b0, {(OPW-1){1'b1}}};

	initial begin
		logic [OPW-1:0] a, b, dir_a[$], dir_b[$];
		int burst;
		int settle;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zeros, signs, ties, extremes and the most negative operand.
		dir_a = '{0, 5, -5, 0, 0, 7, -7, 9, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS,
			MOST_NEG, 1, MOST_POS, 3, -1, 123456, MOST_NEG, 1};
		dir_b = '{0, 0, 0, 9, -9, 7, 7, -7, 0, MOST_NEG, MOST_POS, MOST_NEG,
			MOST_POS, MOST_POS, 1, 4, 1, -654321, 1, MOST_NEG};
		foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);

		// Random pairs in bursts, with a gap after some of them.
		for (int n = 0; n < RANDOM_PAIRS; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < RANDOM_PAIRS; k++, n++) begin
				a = pick_operand();
				b = pick_operand();
				if ($urandom_range(0, 3) == 0) b = a;
				send_pair(a, b);
			end
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		start <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		settle = LATENCY + 10;
		repeat (settle) @(posedge clk);
		$display("Checked %0d rotations from %0d directed and %0d random operand pairs.",
			rotations_checked, dir_a.size(), RANDOM_PAIRS);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Give up if the results stop arriving.
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_front.sv
hw/rtl/sgr_queue.sv
hw/rtl/sgr_back.sv
hw/rtl/stable_givens_rotation.sv
hw/rtl/sgr_checker.sv
bench/stable_givens_rotation_checker.sv
bench/stable_givens_rotation_tb.sv
